// ===== src/fgrd_pkg.sv =====
// Package for the glyph run-length decoder: phase codes, register map,
// configuration and item types, field width helper.
// No dependencies; compiled first.
package fgrd_pkg;

  // Configuration register map (byte address = 4 * index)
  localparam int RegCount = 7;
  localparam int CfgAddrBits = 5;
  localparam logic [2:0] REG_ZERO_RUN = 3'd0;
  localparam logic [2:0] REG_ONE_RUN  = 3'd1;
  localparam logic [2:0] REG_WIDTH    = 3'd2;
  localparam logic [2:0] REG_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_XOFF     = 3'd4;
  localparam logic [2:0] REG_YOFF     = 3'd5;
  localparam logic [2:0] REG_PITCH    = 3'd6;

  // Result kinds
  localparam logic KIND_METRICS = 1'b0;
  localparam logic KIND_RUN     = 1'b1;

  typedef enum logic [3:0] {
    PH_WIDTH,
    PH_HEIGHT,
    PH_XOFF,
    PH_YOFF,
    PH_PITCH,
    PH_ZERO,
    PH_ONE,
    PH_REPEAT,
    PH_IDLE
  } phase_t;

  typedef struct packed {
    logic [3:0] zero_run_bits;
    logic [3:0] one_run_bits;
    logic [3:0] width_bits;
    logic [3:0] height_bits;
    logic [3:0] x_offset_bits;
    logic [3:0] y_offset_bits;
    logic [3:0] pitch_bits;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    zero_run_bits: 4'd4,
    one_run_bits:  4'd4,
    width_bits:    4'd5,
    height_bits:   4'd5,
    x_offset_bits: 4'd4,
    y_offset_bits: 4'd4,
    pitch_bits:    4'd5
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_glyph;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        glyph_width;
    logic [7:0]        glyph_height;
    logic signed [7:0] offset_x;
    logic signed [7:0] offset_y;
    logic [7:0]        pitch;
    logic [15:0]       start_index;
    logic [7:0]        zero_run;
    logic [7:0]        one_run;
    logic              last;
    logic              overflow;
  } out_item_t;

  // Head of the input queue as seen by the decoder
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } queue_head_t;

  // Clamp a register value to 1..8
  function automatic logic [3:0] clamp_bits(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    if (v == 4'd0) r = 4'd1;
    if (v > 4'd8)  r = 4'd8;
    return r;
  endfunction

  // Field width in bits for the header and run-count phases
  function automatic logic [3:0] field_bits(input cfg_t c, input phase_t p);
    logic [3:0] r;
    unique case (p)
      PH_WIDTH:  r = c.width_bits;
      PH_HEIGHT: r = c.height_bits;
      PH_XOFF:   r = c.x_offset_bits;
      PH_YOFF:   r = c.y_offset_bits;
      PH_PITCH:  r = c.pitch_bits;
      PH_ZERO:   r = c.zero_run_bits;
      PH_ONE:    r = c.one_run_bits;
      default:   r = 4'd1;
    endcase
    return clamp_bits(r);
  endfunction

endpackage

// ===== src/fgrd_ifs.sv =====
// Valid/ready channel interfaces for the glyph decoder: byte input and
// result output. Depends on nothing.
interface fgrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_glyph;

  modport source (output valid, output data_byte, output start_glyph, input ready);
  modport sink   (input valid, input data_byte, input start_glyph, output ready);
endinterface

interface fgrd_out_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [7:0]        glyph_width;
  logic [7:0]        glyph_height;
  logic signed [7:0] offset_x;
  logic signed [7:0] offset_y;
  logic [7:0]        pitch;
  logic [15:0]       start_index;
  logic [7:0]        zero_run;
  logic [7:0]        one_run;
  logic              last;
  logic              overflow;

  modport source (output valid, output kind, output glyph_width, output glyph_height,
                  output offset_x, output offset_y, output pitch, output start_index,
                  output zero_run, output one_run, output last, output overflow,
                  input ready);
  modport sink   (input valid, input kind, input glyph_width, input glyph_height,
                  input offset_x, input offset_y, input pitch, input start_index,
                  input zero_run, input one_run, input last, input overflow,
                  output ready);
endinterface

// ===== src/fgrd_cfg.sv =====
// APB-style register file holding the seven field-width registers.
// Depends on fgrd_pkg.
module fgrd_cfg
  import fgrd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CfgAddrBits-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [2:0] reg_idx;
  logic       wr_en;
  logic [3:0] rd_val;

  assign reg_idx = paddr[CfgAddrBits-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ZERO_RUN: cfg.zero_run_bits <= pwdata[3:0];
        REG_ONE_RUN:  cfg.one_run_bits  <= pwdata[3:0];
        REG_WIDTH:    cfg.width_bits    <= pwdata[3:0];
        REG_HEIGHT:   cfg.height_bits   <= pwdata[3:0];
        REG_XOFF:     cfg.x_offset_bits <= pwdata[3:0];
        REG_YOFF:     cfg.y_offset_bits <= pwdata[3:0];
        REG_PITCH:    cfg.pitch_bits    <= pwdata[3:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ZERO_RUN: rd_val = cfg.zero_run_bits;
      REG_ONE_RUN:  rd_val = cfg.one_run_bits;
      REG_WIDTH:    rd_val = cfg.width_bits;
      REG_HEIGHT:   rd_val = cfg.height_bits;
      REG_XOFF:     rd_val = cfg.x_offset_bits;
      REG_YOFF:     rd_val = cfg.y_offset_bits;
      REG_PITCH:    rd_val = cfg.pitch_bits;
      default:      rd_val = 4'd0;
    endcase
  end

  assign prdata = {28'd0, rd_val};

endmodule

// ===== src/fgrd_front.sv =====
// Front end: accepts glyph bytes and holds them in a two-entry queue
// for the bit-serial decoder. Depends on fgrd_pkg and fgrd_in_if.
module fgrd_front
  import fgrd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  fgrd_in_if.sink      in_ch,
  input  logic         pop,
  output queue_head_t  head
);

  in_item_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_ch.ready = (count != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{data_byte: in_ch.data_byte, start_glyph: in_ch.start_glyph};
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.item  = slots[rd_ptr];

endmodule

// ===== src/fgrd_back.sv =====
// Back end: bit-serial header/run-pair decoder, output register. Parsing takes
// one head bit per cycle unless a result waits. Depends on fgrd_pkg, fgrd_out_if.
module fgrd_back
  import fgrd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  queue_head_t  head,
  output logic         pop,
  fgrd_out_if.source   out_ch
);

  // glyph state
  phase_t      phase, phase_next;
  logic [2:0]  bit_idx;
  logic [2:0]  bits_taken, bits_taken_next;
  logic [7:0]  field_accum, field_accum_next;
  logic [7:0]  gw, gw_next, gh, gh_next, gx, gx_next, gy, gy_next, gp, gp_next;
  logic [7:0]  run_zero, run_zero_next, run_one, run_one_next;
  logic [15:0] pix_done, pix_done_next, pix_total, pix_total_next;

  // effective current state (start_glyph clears it at the first bit)
  logic        clr;
  phase_t      cur_phase;
  logic [2:0]  cur_taken;
  logic [7:0]  cur_accum, cur_w, cur_h, cur_x, cur_y, cur_p;
  logic [15:0] cur_done, cur_total;

  logic        in_bit;
  logic [3:0]  fbits;
  logic [7:0]  val;
  logic        field_done;
  logic [7:0]  bias;

  logic [15:0] room, room2, done_sum;
  logic [7:0]  zc, oc;

  logic        out_free;
  logic        step;
  logic        emit;
  out_item_t   emit_item;
  out_item_t   out_item;
  logic        out_valid;

  assign out_free = !out_valid || out_ch.ready;

  always_comb begin
    clr       = head.item.start_glyph && (bit_idx == 3'd0);
    cur_phase = clr ? PH_WIDTH : phase;
    cur_taken = clr ? 3'd0 : bits_taken;
    cur_accum = clr ? 8'd0 : field_accum;
    cur_w     = clr ? 8'd0 : gw;
    cur_h     = clr ? 8'd0 : gh;
    cur_x     = clr ? 8'd0 : gx;
    cur_y     = clr ? 8'd0 : gy;
    cur_p     = clr ? 8'd0 : gp;
    cur_done  = clr ? 16'd0 : pix_done;
    cur_total = clr ? 16'd0 : pix_total;

    in_bit     = head.item.data_byte[bit_idx];
    fbits      = field_bits(cfg, cur_phase);
    val        = cur_accum | (8'(in_bit) << cur_taken);
    field_done = ((4'(cur_taken) + 4'd1) == fbits);
    bias       = 8'd1 << (fbits - 4'd1);

    // run pair clipping against the pixels left in the bitmap
    room     = (cur_total > cur_done) ? (cur_total - cur_done) : 16'd0;
    zc       = ({8'd0, run_zero} < room) ? run_zero : room[7:0];
    room2    = room - {8'd0, zc};
    oc       = ({8'd0, run_one} < room2) ? run_one : room2[7:0];
    done_sum = cur_done + {8'd0, zc} + {8'd0, oc};

    phase_next       = cur_phase;
    bits_taken_next  = cur_taken;
    field_accum_next = cur_accum;
    gw_next          = cur_w;
    gh_next          = cur_h;
    gx_next          = cur_x;
    gy_next          = cur_y;
    gp_next          = cur_p;
    run_zero_next    = run_zero;
    run_one_next     = run_one;
    pix_done_next    = cur_done;
    pix_total_next   = cur_total;
    emit             = 1'b0;
    emit_item        = '0;

    if (cur_phase != PH_REPEAT && cur_phase != PH_IDLE) begin
      bits_taken_next  = field_done ? 3'd0 : (cur_taken + 3'd1);
      field_accum_next = field_done ? 8'd0 : val;
    end

    unique case (cur_phase)
      PH_WIDTH: begin
        if (field_done) begin
          gw_next    = val;
          phase_next = PH_HEIGHT;
        end
      end
      PH_HEIGHT: begin
        if (field_done) begin
          gh_next    = val;
          phase_next = PH_XOFF;
        end
      end
      PH_XOFF: begin
        if (field_done) begin
          gx_next    = val - bias;
          phase_next = PH_YOFF;
        end
      end
      PH_YOFF: begin
        if (field_done) begin
          gy_next    = val - bias;
          phase_next = PH_PITCH;
        end
      end
      PH_PITCH: begin
        if (field_done) begin
          gp_next        = val;
          pix_total_next = 16'(cur_w) * 16'(cur_h);
          pix_done_next  = 16'd0;
          emit           = 1'b1;
          emit_item.kind = KIND_METRICS;
          emit_item.last = (cur_w == 8'd0) || (cur_h == 8'd0);
          phase_next     = emit_item.last ? PH_IDLE : PH_ZERO;
        end
      end
      PH_ZERO: begin
        if (field_done) begin
          run_zero_next = val;
          phase_next    = PH_ONE;
        end
      end
      PH_ONE: begin
        if (field_done) begin
          run_one_next = val;
          phase_next   = PH_REPEAT;
        end
      end
      PH_REPEAT: begin
        // one pass of the pair, reported on its repeat bit
        emit                  = 1'b1;
        emit_item.kind        = KIND_RUN;
        emit_item.start_index = cur_done;
        emit_item.zero_run    = zc;
        emit_item.one_run     = oc;
        emit_item.last        = !in_bit && (done_sum >= cur_total);
        emit_item.overflow    = (zc != run_zero) || (oc != run_one);
        pix_done_next         = done_sum;
        if (in_bit)                     phase_next = PH_REPEAT;
        else if (done_sum >= cur_total) phase_next = PH_IDLE;
        else                            phase_next = PH_ZERO;
      end
      PH_IDLE: ;
      default: phase_next = PH_IDLE;
    endcase

    emit_item.glyph_width  = gw_next;
    emit_item.glyph_height = gh_next;
    emit_item.offset_x     = gx_next;
    emit_item.offset_y     = gy_next;
    emit_item.pitch        = gp_next;
  end

  // only a bit that makes a result waits on the output side; idle bytes drain
  assign step = head.valid && (!emit || out_free);
  assign pop  = step && ((bit_idx == 3'd7) || (cur_phase == PH_IDLE));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WIDTH;
      bit_idx     <= 3'd0;
      bits_taken  <= 3'd0;
      field_accum <= 8'd0;
      gw          <= 8'd0;
      gh          <= 8'd0;
      gx          <= 8'd0;
      gy          <= 8'd0;
      gp          <= 8'd0;
      run_zero    <= 8'd0;
      run_one     <= 8'd0;
      pix_done    <= 16'd0;
      pix_total   <= 16'd0;
    end else if (step) begin
      phase       <= phase_next;
      bit_idx     <= pop ? 3'd0 : (bit_idx + 3'd1);
      bits_taken  <= bits_taken_next;
      field_accum <= field_accum_next;
      gw          <= gw_next;
      gh          <= gh_next;
      gx          <= gx_next;
      gy          <= gy_next;
      gp          <= gp_next;
      run_zero    <= run_zero_next;
      run_one     <= run_one_next;
      pix_done    <= pix_done_next;
      pix_total   <= pix_total_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_item <= emit_item;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.kind         = out_item.kind;
  assign out_ch.glyph_width  = out_item.glyph_width;
  assign out_ch.glyph_height = out_item.glyph_height;
  assign out_ch.offset_x     = out_item.offset_x;
  assign out_ch.offset_y     = out_item.offset_y;
  assign out_ch.pitch        = out_item.pitch;
  assign out_ch.start_index  = out_item.start_index;
  assign out_ch.zero_run     = out_item.zero_run;
  assign out_ch.one_run      = out_item.one_run;
  assign out_ch.last         = out_item.last;
  assign out_ch.overflow     = out_item.overflow;

endmodule

// ===== src/font_glyph_rle_decoder.sv =====
// Top level of the glyph run-length decoder: register file, input queue
// and bit-serial decoder. Depends on fgrd_pkg, fgrd_ifs, fgrd_cfg,
// fgrd_front and fgrd_back.
//
// Usage:
//  - in_ch carries compressed glyph bytes (data_byte, start_glyph). A byte
//    with start_glyph = 1 restarts the header parse at its bit 0.
//  - out_ch carries one transaction per metrics item or run-pair pass.
//  - The APB port sets the seven field widths; write them only while the
//    decoder is idle. pready is tied high.
// Throughput: one bit per cycle through the bit-serial decoder unless a
//   result stalls it; bytes that arrive after a glyph has ended are dropped
//   whole, without a bit-serial pass. Each bit yields at most one result.
// Path: a byte is written into a queue slot, its bits are parsed from the
//   queue head, and each result is registered in out_item before out_ch.
// Reset (rst, synchronous): queue emptied, output cleared, registers back
//   to their defaults, parser at the header width field.
// Stall: while out_ch holds a result that is not taken and the next bit
//   would make another, the decoder waits; the two-entry queue then fills
//   and in_ch.ready drops.
module font_glyph_rle_decoder
  import fgrd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  fgrd_in_if.sink                in_ch,
  fgrd_out_if.source             out_ch,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CfgAddrBits-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cfg_t        cfg;
  queue_head_t head;
  logic        pop;

  fgrd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front: byte queue between the channel and the decoder
  fgrd_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .pop   (pop),
    .head  (head)
  );

  // back: bit-serial parse and result register
  fgrd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
